/* rtl/vfc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vfc_pkg;

   // Side of the owning block that a visible face lies on.
   typedef enum logic [2:0] {
      DIR_TOP    = 3'd0,
      DIR_BOTTOM = 3'd1,
      DIR_FRONT  = 3'd2,
      DIR_BACK   = 3'd3,
      DIR_RIGHT  = 3'd4,
      DIR_LEFT   = 3'd5
   } face_dir_type;

   localparam int unsigned TYPE_PORT_BITS  = 8;
   localparam int unsigned COORD_XZ_BITS   = 4;
   localparam int unsigned COORD_Y_BITS    = 8;

endpackage

`default_nettype wire

/* rtl/vfc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module vfc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the entry being written in the same cycle returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/voxel_face_culling.sv */
// Visible-face finder for one voxel chunk.
// Block types enter on the req_ channel one beat per block in scan order
// (x fastest, then z, then y); req_chunk_start marks the first block of a
// chunk and restarts the scan position. For each neighbor pair inside the
// chunk where exactly one block is air, one face beat leaves on the rsp_
// channel, owned by the solid block and facing the air. The pairs of one
// block are reported in the order below, behind, left, and rsp_run_last
// flags the last face of that block. csr_we/csr_wdata load the air code
// (reset 0); write it only while the block is idle.
// An accepted block moves from stage 1 (the layer-store read) into the stage 2
// output register, whose faces leave on rsp_. Throughput: one block per cycle
// while each block makes at most one face and rsp_ready is high; a block with
// more faces holds the register until its last face goes. The limit is the
// single rsp_ output register; the layer store is read at two ports in parallel
// (below and behind), and the left neighbor comes from the previous beat.
// Reset clears the scan position, the air code and the pipeline. The layer
// store is not cleared, since each entry is written before it is read.
// When rsp_ready is low the face is held and req_ready drops once the
// internal stage behind the output register is also full.
`timescale 1ns / 1ps
`default_nettype none

module voxel_face_culling
   import vfc_pkg::*;
#(
   parameter int unsigned SIZE_X    = 16,
   parameter int unsigned SIZE_Y    = 256,
   parameter int unsigned SIZE_Z    = 16,
   parameter int unsigned TYPE_BITS = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_block_type,
   input  wire logic       req_chunk_start,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [3:0]      rsp_face_x,
   output logic [7:0]      rsp_face_y,
   output logic [3:0]      rsp_face_z,
   output logic [2:0]      rsp_face_dir,
   output logic [7:0]      rsp_face_block_type,
   output logic            rsp_run_last,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata
);

   localparam int unsigned TW    = (TYPE_BITS < TYPE_PORT_BITS) ? TYPE_BITS : TYPE_PORT_BITS;
   localparam int unsigned XW    = $clog2(SIZE_X);
   localparam int unsigned YW    = $clog2(SIZE_Y);
   localparam int unsigned ZW    = $clog2(SIZE_Z);
   localparam int unsigned LAYER = SIZE_X * SIZE_Z;
   localparam int unsigned AW    = $clog2(LAYER);

   // Scan position and configuration.
   logic [XW-1:0] pos_x_ff, pos_x_in;
   logic [YW-1:0] pos_y_ff, pos_y_in;
   logic [ZW-1:0] pos_z_ff, pos_z_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [TW-1:0] air_ff, air_in;
   logic [TW-1:0] prev_type_ff;

   logic          req_fire;
   logic [XW-1:0] cur_x;
   logic [YW-1:0] cur_y;
   logic [ZW-1:0] cur_z;
   logic [AW-1:0] cur_idx;
   logic [TW-1:0] cur_type;
   logic [TW-1:0] below_rd, behind_rd;

   // Stage 1: store read in flight.
   logic          s1_valid_ff, s1_valid_in;
   logic [XW-1:0] s1_x_ff;
   logic [YW-1:0] s1_y_ff;
   logic [ZW-1:0] s1_z_ff;
   logic [TW-1:0] s1_cur_ff;
   logic [TW-1:0] s1_left_ff;
   logic          s1_adv;

   // Stage 2: output register with a mask of faces still to send.
   logic [2:0]    s2_mask_ff, s2_mask_in;
   logic [2:0]    s2_nb_air_ff;
   logic [XW-1:0] s2_x_ff;
   logic [YW-1:0] s2_y_ff;
   logic [ZW-1:0] s2_z_ff;
   logic [TW-1:0] s2_cur_ff, s2_below_ff, s2_behind_ff, s2_left_ff;
   logic          s2_free;
   logic          rsp_fire;

   logic [2:0]    s1_mask, s1_nb_air;
   logic          cur_air, below_air, behind_air, left_air;
   logic [2:0]    mask_rest;

   logic [XW-1:0]  o_x;
   logic [YW-1:0]  o_y;
   logic [ZW-1:0]  o_z;
   face_dir_type   o_dir;
   logic [TW-1:0]  o_type;

   assign req_fire = req_valid && req_ready;
   assign cur_type = req_block_type[TW-1:0];

   always_comb begin
      cur_x   = req_chunk_start ? '0 : pos_x_ff;
      cur_y   = req_chunk_start ? '0 : pos_y_ff;
      cur_z   = req_chunk_start ? '0 : pos_z_ff;
      cur_idx = req_chunk_start ? '0 : idx_ff;

      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      idx_in   = idx_ff;
      if (req_fire) begin
         idx_in = (cur_idx == AW'(LAYER - 1)) ? '0 : cur_idx + AW'(1);
         pos_y_in = cur_y;
         pos_z_in = cur_z;
         if (cur_x == XW'(SIZE_X - 1)) begin
            pos_x_in = '0;
            if (cur_z == ZW'(SIZE_Z - 1)) begin
               pos_z_in = '0;
               pos_y_in = (cur_y == YW'(SIZE_Y - 1)) ? '0 : cur_y + YW'(1);
            end else begin
               pos_z_in = cur_z + ZW'(1);
            end
         end else begin
            pos_x_in = cur_x + XW'(1);
         end
      end
      air_in = csr_we ? csr_wdata[TW-1:0] : air_ff;
   end

   // Two copies of the layer: one read below (same entry), one read behind.
   vfc_ram #(
      .WIDTH (TW),
      .DEPTH (LAYER)
   ) u_below_ram (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (cur_idx),
      .wr_data (cur_type),
      .rd_en   (req_fire),
      .rd_addr (cur_idx),
      .rd_data (below_rd)
   );

   vfc_ram #(
      .WIDTH (TW),
      .DEPTH (LAYER)
   ) u_behind_ram (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (cur_idx),
      .wr_data (cur_type),
      .rd_en   (req_fire),
      .rd_addr (cur_idx - AW'(SIZE_X)),
      .rd_data (behind_rd)
   );

   // Face selection for the block in stage 1.
   always_comb begin
      cur_air    = (s1_cur_ff == air_ff);
      below_air  = (below_rd == air_ff);
      behind_air = (behind_rd == air_ff);
      left_air   = (s1_left_ff == air_ff);
      s1_mask[0] = (s1_y_ff != '0) && (below_air != cur_air);
      s1_mask[1] = (s1_z_ff != '0) && (behind_air != cur_air);
      s1_mask[2] = (s1_x_ff != '0) && (left_air != cur_air);
      s1_nb_air  = {left_air, behind_air, below_air};
   end

   assign mask_rest = s2_mask_ff & (s2_mask_ff - 3'd1);
   assign rsp_valid = (s2_mask_ff != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign s2_free   = !rsp_valid || (rsp_ready && (mask_rest == '0));
   assign s1_adv    = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      s2_mask_in = s2_mask_ff;
      if (s1_adv) begin
         s2_mask_in = s1_mask;
      end else if (rsp_fire) begin
         s2_mask_in = mask_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff    <= '0;
         pos_y_ff    <= '0;
         pos_z_ff    <= '0;
         idx_ff      <= '0;
         air_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_mask_ff  <= '0;
      end else begin
         pos_x_ff    <= pos_x_in;
         pos_y_ff    <= pos_y_in;
         pos_z_ff    <= pos_z_in;
         idx_ff      <= idx_in;
         air_ff      <= air_in;
         s1_valid_ff <= s1_valid_in;
         s2_mask_ff  <= s2_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         prev_type_ff <= cur_type;
         s1_x_ff      <= cur_x;
         s1_y_ff      <= cur_y;
         s1_z_ff      <= cur_z;
         s1_cur_ff    <= cur_type;
         s1_left_ff   <= prev_type_ff;
      end
      if (s1_adv) begin
         s2_nb_air_ff <= s1_nb_air;
         s2_x_ff      <= s1_x_ff;
         s2_y_ff      <= s1_y_ff;
         s2_z_ff      <= s1_z_ff;
         s2_cur_ff    <= s1_cur_ff;
         s2_below_ff  <= below_rd;
         s2_behind_ff <= behind_rd;
         s2_left_ff   <= s1_left_ff;
      end
   end

   // The lowest pending pair goes out first; an air neighbor puts the face on
   // the current block, otherwise on the neighbor.
   always_comb begin
      o_x    = s2_x_ff;
      o_y    = s2_y_ff;
      o_z    = s2_z_ff;
      o_dir  = DIR_LEFT;
      o_type = s2_cur_ff;
      if (s2_mask_ff[0]) begin
         if (s2_nb_air_ff[0]) begin
            o_dir = DIR_BOTTOM;
         end else begin
            o_y    = s2_y_ff - YW'(1);
            o_dir  = DIR_TOP;
            o_type = s2_below_ff;
         end
      end else if (s2_mask_ff[1]) begin
         if (s2_nb_air_ff[1]) begin
            o_dir = DIR_BACK;
         end else begin
            o_z    = s2_z_ff - ZW'(1);
            o_dir  = DIR_FRONT;
            o_type = s2_behind_ff;
         end
      end else if (!s2_nb_air_ff[2]) begin
         o_x    = s2_x_ff - XW'(1);
         o_dir  = DIR_RIGHT;
         o_type = s2_left_ff;
      end
   end

   assign rsp_face_x          = COORD_XZ_BITS'(32'(o_x));
   assign rsp_face_y          = COORD_Y_BITS'(32'(o_y));
   assign rsp_face_z          = COORD_XZ_BITS'(32'(o_z));
   assign rsp_face_dir        = o_dir;
   assign rsp_face_block_type = TYPE_PORT_BITS'(32'(o_type));
   assign rsp_run_last        = (mask_rest == '0);

endmodule

`default_nettype wire

/* rtl/vfc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module vfc_checker
   import vfc_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [3:0] rsp_face_x,
   input wire logic [7:0] rsp_face_y,
   input wire logic [3:0] rsp_face_z,
   input wire logic [2:0] rsp_face_dir,
   input wire logic [7:0] rsp_face_block_type,
   input wire logic       rsp_run_last
);

   // The pipeline is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("face beat shown right after reset");

   // A block's faces leave back to back until the one marked last.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_run_last) |=> rsp_valid)
      else $error("face run broken before its last beat");

   // A stalled face beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_face_x) && $stable(rsp_face_y) &&
          $stable(rsp_face_z) && $stable(rsp_face_dir) &&
          $stable(rsp_face_block_type) && $stable(rsp_run_last)))
      else $error("stalled face beat changed");

   // Only the six defined sides appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_face_dir <= 3'(DIR_LEFT)))
      else $error("face direction out of range");

endmodule

bind voxel_face_culling vfc_checker u_vfc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_face_x          (rsp_face_x),
   .rsp_face_y          (rsp_face_y),
   .rsp_face_z          (rsp_face_z),
   .rsp_face_dir        (rsp_face_dir),
   .rsp_face_block_type (rsp_face_block_type),
   .rsp_run_last        (rsp_run_last)
);

`default_nettype wire
